// ===== hw/rtl/aip_pkg.sv =====
// Shared types and constants for the ASCII integer parser.
package aip_pkg;

  localparam int CHAR_BITS      = 8;
  localparam int VALUE_BITS     = 64;
  localparam int MAX_COUNT      = 64;
  localparam int COUNT_BITS     = $clog2(MAX_COUNT + 1);
  localparam int BASE_BITS      = 6;
  localparam int OUT_VALUE_BITS = 64;
  localparam int IN_TDATA_BITS  = ((CHAR_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((OUT_VALUE_BITS + COUNT_BITS + 1 + 7) / 8) * 8;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX       = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNED_MODE = CFG_INDEX_BITS'(1);

  localparam logic [BASE_BITS-1:0] BASE_OCT     = BASE_BITS'(8);
  localparam logic [BASE_BITS-1:0] BASE_DEC     = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_HEX     = BASE_BITS'(16);
  localparam logic [BASE_BITS-1:0] BASE_UNARY   = BASE_BITS'(1);
  localparam logic [BASE_BITS-1:0] BASE_MAX     = BASE_BITS'(36);
  localparam logic [BASE_BITS-1:0] BASE_AUTO    = BASE_BITS'(0);

  typedef struct packed {
    logic [CHAR_BITS-1:0] character;
    logic                 first;
  } item_t;

  typedef struct packed {
    logic                      overflow;
    logic [COUNT_BITS-1:0]     consumed_count;
    logic [OUT_VALUE_BITS-1:0] value;
  } result_t;

endpackage

// ===== hw/rtl/ascii_integer_parser_unit.sv =====
// Top level of the ASCII integer parser: configuration registers and stage wiring.
// Streams characters in, one per cycle while not stalled, and returns one item
// per number: the parsed value, the count of consumed characters and an overflow
// flag. Leading white space, a sign, with radix 0 a 0 or 0x prefix and with radix
// 16 a 0x prefix are handled; the first character that is no digit of the base
// ends the number and is not counted. A new string starts at an item with in_tuser
// high. The input stalls while the result register is full and out_tready is low;
// a result is shown on out_tvalid once its stop character has passed the input
// and result registers. The cycle time is set by the 64-by-6-bit multiply-add of
// the accumulator. Write radix and signed_mode only while no string is in flight.
module ascii_integer_parser_unit import aip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // character
  input  logic                      in_tuser,   // first
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // value, consumed_count, overflow
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [BASE_BITS-1:0]      cfg_wdata
);

  logic [BASE_BITS-1:0] radix_r;
  logic                 signed_mode_r;
  logic                 item_valid, room, fire, res_valid;
  item_t                item;
  result_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r       <= BASE_AUTO;
      signed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:       radix_r       <= cfg_wdata;
        REG_SIGNED_MODE: signed_mode_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign fire = item_valid && room;

  aip_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  aip_parse_core u_parse_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (item),
    .radix       (radix_r),
    .signed_mode (signed_mode_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  aip_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && res_valid),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/aip_in_stage.sv =====
// Input register of the ASCII integer parser.
module aip_in_stage import aip_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_BITS-1:0] in_tdata,
  input  logic                     in_tuser,
  input  logic                     take,
  output logic                     item_valid,
  output item_t                    item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign in_tready = !valid_r || take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt          = 1'b1;
      item_nxt.character = in_tdata[CHAR_BITS-1:0];
      item_nxt.first     = in_tuser;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/aip_parse_core.sv =====
// Parse state and per-character datapath of the ASCII integer parser.
module aip_parse_core import aip_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  item_t                item,
  input  logic [BASE_BITS-1:0] radix,
  input  logic                 signed_mode,
  output logic                 res_valid,
  output result_t              res
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEAD   = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_ZEROX  = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  localparam int PROD_BITS = VALUE_BITS + BASE_BITS + 1;

  localparam logic [CHAR_BITS-1:0] CH_0     = CHAR_BITS'(8'h30);
  localparam logic [CHAR_BITS-1:0] CH_9     = CHAR_BITS'(8'h39);
  localparam logic [CHAR_BITS-1:0] CH_UA    = CHAR_BITS'(8'h41);
  localparam logic [CHAR_BITS-1:0] CH_UZ    = CHAR_BITS'(8'h5a);
  localparam logic [CHAR_BITS-1:0] CH_LA    = CHAR_BITS'(8'h61);
  localparam logic [CHAR_BITS-1:0] CH_LZ    = CHAR_BITS'(8'h7a);
  localparam logic [CHAR_BITS-1:0] CH_UX    = CHAR_BITS'(8'h58);
  localparam logic [CHAR_BITS-1:0] CH_LX    = CHAR_BITS'(8'h78);
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = CHAR_BITS'(8'h2b);
  localparam logic [CHAR_BITS-1:0] CH_MINUS = CHAR_BITS'(8'h2d);
  localparam logic [CHAR_BITS-1:0] CH_SPACE = CHAR_BITS'(8'h20);
  localparam logic [CHAR_BITS-1:0] CH_TAB   = CHAR_BITS'(8'h09);
  localparam logic [CHAR_BITS-1:0] CH_CR    = CHAR_BITS'(8'h0d);
  localparam logic [CHAR_BITS-1:0] UPPER_OFS = CHAR_BITS'(8'h37);
  localparam logic [CHAR_BITS-1:0] LOWER_OFS = CHAR_BITS'(8'h57);

  phase_t                phase_r, phase_nxt, phase_cur;
  logic                  minus_r, minus_nxt, minus_cur;
  logic [BASE_BITS-1:0]  base_r, base_nxt, base_cur, base_eff, mul_base;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt, acc_cur;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_cur;
  logic                  ovf_r, ovf_nxt, ovf_cur;

  logic [CHAR_BITS-1:0]  c;
  logic [BASE_BITS-1:0]  digit;
  logic                  is_digit, is_space, bad_radix;
  logic                  sig_path, do_acc, emit, conv;
  logic [1:0]            cnt_inc;
  logic [COUNT_BITS:0]   cnt_sum;
  logic [PROD_BITS-1:0]  prod;
  logic                  range_ovf;
  logic [VALUE_BITS-1:0] signed_val;

  assign c = item.character;

  always_comb begin
    digit    = '0;
    is_digit = 1'b1;
    if (c >= CH_0 && c <= CH_9) begin
      digit = BASE_BITS'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      digit = BASE_BITS'(c - UPPER_OFS);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      digit = BASE_BITS'(c - LOWER_OFS);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign is_space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign bad_radix = (radix == BASE_UNARY) || (radix > BASE_MAX);

  assign prod = PROD_BITS'(acc_cur) * PROD_BITS'(mul_base) + PROD_BITS'(digit);

  always_comb begin
    if (item.first) begin
      phase_cur = bad_radix ? PH_IDLE : PH_LEAD;
      minus_cur = 1'b0;
      base_cur  = radix;
      acc_cur   = '0;
      cnt_cur   = '0;
      ovf_cur   = 1'b0;
    end else begin
      phase_cur = phase_r;
      minus_cur = minus_r;
      base_cur  = base_r;
      acc_cur   = acc_r;
      cnt_cur   = cnt_r;
      ovf_cur   = ovf_r;
    end

    phase_nxt = phase_cur;
    minus_nxt = minus_cur;
    base_nxt  = base_cur;
    base_eff  = base_cur;
    mul_base  = base_cur;
    acc_nxt   = acc_cur;
    ovf_nxt   = ovf_cur;
    sig_path  = 1'b0;
    do_acc    = 1'b0;
    emit      = item.first && bad_radix;
    conv      = 1'b0;
    cnt_inc   = 2'd0;

    case (phase_cur)
      PH_LEAD: begin
        if (is_space) begin
          cnt_inc = 2'd1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          minus_nxt = (c == CH_MINUS);
          cnt_inc   = 2'd1;
          phase_nxt = PH_SIGNED;
        end else begin
          sig_path = 1'b1;
        end
      end
      PH_SIGNED: begin
        sig_path = 1'b1;
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          phase_nxt = PH_ZEROX;
        end else begin
          base_eff = (base_cur == BASE_AUTO) ? BASE_OCT : base_cur;
          base_nxt = base_eff;
          mul_base = base_eff;
          if (is_digit && digit < base_eff) begin
            do_acc = 1'b1;
          end else begin
            emit = 1'b1;
            conv = 1'b1;
          end
        end
      end
      PH_ZEROX: begin
        if (is_digit && digit < BASE_HEX) begin
          base_nxt = BASE_HEX;
          mul_base = BASE_HEX;
          cnt_inc  = 2'd1;
          do_acc   = 1'b1;
        end else begin
          emit = 1'b1;
          conv = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (is_digit && digit < base_cur) begin
          do_acc = 1'b1;
        end else begin
          emit = 1'b1;
          conv = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (sig_path) begin
      if (c == CH_0 && (base_cur == BASE_AUTO || base_cur == BASE_HEX)) begin
        cnt_inc   = 2'd1;
        phase_nxt = PH_ZERO;
      end else begin
        base_eff = (base_cur == BASE_AUTO) ? BASE_DEC : base_cur;
        base_nxt = base_eff;
        mul_base = base_eff;
        if (is_digit && digit < base_eff) begin
          do_acc = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
    end

    if (do_acc) begin
      acc_nxt   = prod[VALUE_BITS-1:0];
      ovf_nxt   = ovf_cur || (|prod[PROD_BITS-1:VALUE_BITS]);
      phase_nxt = PH_DIGITS;
    end
    if (emit) begin
      phase_nxt = PH_IDLE;
    end

    cnt_sum = (COUNT_BITS+1)'(cnt_cur) + (COUNT_BITS+1)'(cnt_inc)
            + (COUNT_BITS+1)'(do_acc);
    cnt_nxt = (cnt_sum > (COUNT_BITS+1)'(MAX_COUNT)) ? COUNT_BITS'(MAX_COUNT)
                                                     : cnt_sum[COUNT_BITS-1:0];
  end

  assign signed_val = minus_cur ? (VALUE_BITS'(0) - acc_cur) : acc_cur;
  assign range_ovf  = signed_mode &&
                      (minus_cur ? (acc_cur[VALUE_BITS-1] && (|acc_cur[VALUE_BITS-2:0]))
                                 : acc_cur[VALUE_BITS-1]);

  always_comb begin
    res_valid = emit;
    res       = '0;
    if (conv) begin
      res.value          = OUT_VALUE_BITS'(signed_val);
      res.consumed_count = cnt_cur;
      res.overflow       = ovf_cur || range_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      minus_r <= 1'b0;
      base_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      minus_r <= minus_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_BITS'(MAX_COUNT))
    else $error("consumed count above saturation limit");

  a_emit_idles: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> phase_r == PH_IDLE)
    else $error("phase not idle after a result");

  a_digits_base: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DIGITS |-> (base_r >= BASE_BITS'(2) && base_r <= BASE_MAX))
    else $error("digit phase with an unusable base");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && res.consumed_count == '0 |-> res.value == '0 && !res.overflow)
    else $error("result with no consumed characters is not zero");
`endif

endmodule

// ===== hw/rtl/aip_out_stage.sv =====
// Result register of the ASCII integer parser.
module aip_out_stage import aip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  result_t                   res,
  output logic                      room,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign room = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_TDATA_BITS'(res_r);

endmodule
